>>> hdl/wpm_pkg.sv
// Shared constants and types for the wildcard pattern matcher.
// Used by wpm_front, wpm_queue, wpm_back and the top level; no dependencies.
package wpm_pkg;

	// Store capacities and the derived index and length widths
	localparam int MAX_PATTERN = 256;
	localparam int MAX_TEXT    = 256;
	localparam int PAT_AW      = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int TXT_AW      = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1;
	localparam int PAT_LW      = $clog2(MAX_PATTERN + 1);
	localparam int TXT_LW      = $clog2(MAX_TEXT + 1);

	// Request function codes as they arrive on the input port
	localparam logic [1:0] FUNC_PAT = 2'd0;
	localparam logic [1:0] FUNC_TXT = 2'd1;
	localparam logic [1:0] FUNC_CMP = 2'd2;

	// Operation codes carried through the command queue
	localparam logic [1:0] OP_PAT = 2'd0;
	localparam logic [1:0] OP_TXT = 2'd1;
	localparam logic [1:0] OP_CMP = 2'd2;

	// Wildcard characters in the pattern
	localparam logic [7:0] CH_ANY = 8'h3F;
	localparam logic [7:0] CH_RUN = 8'h2A;

	// Command queue depth
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] data;
	} cmd_t;

	// Queue status: valid goes to the back end, full goes to the front end
	typedef struct packed {
		logic valid;
		logic full;
	} q_status_t;

endpackage

>>> hdl/wpm_front.sv
// Front end: accepts requests, decodes the function code, drops unused codes.
// Depends on wpm_pkg; feeds wpm_queue.
module wpm_front import wpm_pkg::*; (
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] func,
	input  logic [7:0] byte_value,
	input  q_status_t  q_stat,
	output logic       push,
	output cmd_t       push_cmd
);

	logic known;

	// Classify the request
	always_comb begin
		known         = 1'b1;
		push_cmd.data = byte_value;
		unique case (func)
			FUNC_PAT: push_cmd.op = OP_PAT;
			FUNC_TXT: push_cmd.op = OP_TXT;
			FUNC_CMP: push_cmd.op = OP_CMP;
			default: begin
				push_cmd.op = OP_PAT;
				known       = 1'b0;
			end
		endcase
	end

	// Hold the request while the queue is full; drop unknown codes
	assign in_stall = q_stat.full;
	assign push     = in_valid && !q_stat.full && known;

endmodule

>>> hdl/wpm_queue.sv
// Short command queue between front and back end.
// Depends on wpm_pkg.
module wpm_queue import wpm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  cmd_t      push_cmd,
	input  logic      pop,
	output cmd_t      head_cmd,
	output q_status_t q_stat
);

	localparam int CW = $clog2(QDEPTH + 1);

	cmd_t            entry_q [QDEPTH];
	logic [QAW-1:0]  wr_ptr_q;
	logic [QAW-1:0]  rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign q_stat.valid = (count_q != '0);
	assign q_stat.full  = (count_q == CW'(QDEPTH));
	assign head_cmd     = entry_q[rd_ptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_q + QAW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_q + QAW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

>>> hdl/wpm_back.sv
// Back end: pattern and text stores, greedy wildcard matcher, result register.
// Depends on wpm_pkg; pops commands from wpm_queue.
module wpm_back import wpm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  q_status_t q_stat,
	input  cmd_t      head_cmd,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_stall,
	output logic      matched,
	output logic      overflowed
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_EVAL = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [7:0]        pat_mem [MAX_PATTERN];
	logic [7:0]        txt_mem [MAX_TEXT];
	logic [7:0]        p_rd_q;
	logic [7:0]        t_rd_q;

	logic [1:0]        state_q;
	logic [PAT_LW-1:0] plen_q;
	logic [TXT_LW-1:0] tlen_q;
	logic              ovf_q;
	logic [PAT_LW-1:0] pj_q;
	logic [TXT_LW-1:0] ti_q;
	logic [PAT_LW-1:0] rp_q;
	logic [TXT_LW-1:0] rt_q;
	logic              have_run_q;
	logic              res_q;
	logic              out_valid_q;
	logic              matched_q;
	logic              overflowed_q;

	logic              pat_we;
	logic              txt_we;
	logic              p_in;
	logic              t_in;
	logic              p_star;
	logic              p_hit;

	assign pop    = (state_q == ST_IDLE) && q_stat.valid;
	assign pat_we = pop && (head_cmd.op == OP_PAT) && (plen_q < PAT_LW'(MAX_PATTERN));
	assign txt_we = pop && (head_cmd.op == OP_TXT) && (tlen_q < TXT_LW'(MAX_TEXT));

	assign p_in   = (pj_q < plen_q);
	assign t_in   = (ti_q < tlen_q);
	assign p_star = p_in && (p_rd_q == CH_RUN);
	assign p_hit  = p_in && ((p_rd_q == CH_ANY) || (p_rd_q == t_rd_q));

	assign out_valid  = out_valid_q;
	assign matched    = matched_q;
	assign overflowed = overflowed_q;

	// Stores: one write port, one registered read port each
	always_ff @(posedge clk) begin
		if (pat_we) begin
			pat_mem[plen_q[PAT_AW-1:0]] <= head_cmd.data;
		end
		p_rd_q <= pat_mem[pj_q[PAT_AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (txt_we) begin
			txt_mem[tlen_q[TXT_AW-1:0]] <= head_cmd.data;
		end
		t_rd_q <= txt_mem[ti_q[TXT_AW-1:0]];
	end

	// Sequence appends, matcher steps and result delivery
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			plen_q       <= '0;
			tlen_q       <= '0;
			ovf_q        <= 1'b0;
			pj_q         <= '0;
			ti_q         <= '0;
			rp_q         <= '0;
			rt_q         <= '0;
			have_run_q   <= 1'b0;
			res_q        <= 1'b0;
			out_valid_q  <= 1'b0;
			matched_q    <= 1'b0;
			overflowed_q <= 1'b0;
		end else begin
			// drop the result once taken, unless a new one replaces it
			if (out_valid_q && !out_stall && (state_q != ST_OUT)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						unique case (head_cmd.op)
							OP_PAT: begin
								if (pat_we) begin
									plen_q <= plen_q + PAT_LW'(1);
								end else begin
									ovf_q <= 1'b1;
								end
							end
							OP_TXT: begin
								if (txt_we) begin
									tlen_q <= tlen_q + TXT_LW'(1);
								end else begin
									ovf_q <= 1'b1;
								end
							end
							OP_CMP: begin
								pj_q       <= '0;
								ti_q       <= '0;
								have_run_q <= 1'b0;
								state_q    <= ST_READ;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_READ: begin
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					state_q <= ST_READ;
					if (t_in) begin
						if (p_star) begin
							have_run_q <= 1'b1;
							pj_q       <= pj_q + PAT_LW'(1);
							rp_q       <= pj_q + PAT_LW'(1);
							rt_q       <= ti_q;
						end else if (p_hit) begin
							pj_q <= pj_q + PAT_LW'(1);
							ti_q <= ti_q + TXT_LW'(1);
						end else if (have_run_q) begin
							rt_q <= rt_q + TXT_LW'(1);
							ti_q <= rt_q + TXT_LW'(1);
							pj_q <= rp_q;
						end else begin
							res_q   <= 1'b0;
							state_q <= ST_OUT;
						end
					end else begin
						// skip trailing stars, then require the pattern to be used up
						if (p_star) begin
							pj_q <= pj_q + PAT_LW'(1);
						end else begin
							res_q   <= !p_in;
							state_q <= ST_OUT;
						end
					end
				end
				ST_OUT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q  <= 1'b1;
						matched_q    <= res_q;
						overflowed_q <= ovf_q;
						plen_q       <= '0;
						tlen_q       <= '0;
						ovf_q        <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> hdl/wildcard_pattern_matcher_core.sv
// Wildcard pattern matcher, top level: front end, command queue, back end.
// Appends sustain one request per cycle in the back end while no compare is in progress.
// A compare runs matcher steps, each a store read and then an evaluate, with the
// steps bounded by about text_length * (pattern_length + 1) with backtracking.
// Reset clears lengths, overflow flag, queue and output; stores are left as is.
// Depends on wpm_pkg, wpm_front, wpm_queue and wpm_back.
module wildcard_pattern_matcher_core import wpm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] func,
	input  logic [7:0] byte_value,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       matched,
	output logic       overflowed
);

	q_status_t q_stat;
	logic      push;
	logic      pop;
	cmd_t      push_cmd;
	cmd_t      head_cmd;

	// Decode requests
	wpm_front u_front (
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.func       (func),
		.byte_value (byte_value),
		.q_stat     (q_stat),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	// Decouple front and back
	wpm_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head_cmd (head_cmd),
		.q_stat   (q_stat)
	);

	// Execute commands
	wpm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_stat     (q_stat),
		.head_cmd   (head_cmd),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.matched    (matched),
		.overflowed (overflowed)
	);

endmodule
